>>> rtl/pbad_pkg.sv
// ----------------------------------------------------------------------------
// pbad_pkg
// Shared widths, codes and beat types of the block-average downscaler.
// ----------------------------------------------------------------------------
package pbad_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;
  localparam int unsigned MAX_BLOCK  = 64;

  localparam int unsigned NCHAN      = 3;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned IMG_W_W    = 12;
  localparam int unsigned BLK_W      = 7;
  localparam int unsigned SUB_W      = 6;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  // A row share holds up to one tile width of pixels, a band sum one tile height of rows.
  localparam int unsigned PART_W     = CHAN_W + SUB_W;
  localparam int unsigned BAND_W     = PART_W + SUB_W;
  localparam int unsigned AREA_W     = 2 * SUB_W + 1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = IMG_W_W'(1920);
  localparam logic [BLK_W-1:0]   BLOCK_WIDTH_RST  = BLK_W'(1);
  localparam logic [BLK_W-1:0]   BLOCK_HEIGHT_RST = BLK_W'(1);

  typedef enum logic [1:0] {
    FORM_RGB6 = 2'd0,
    FORM_RGB3 = 2'd1,
    FORM_GREY = 2'd2
  } color_form_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_BLOCK_WIDTH  = 2'd1,
    REG_BLOCK_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  color_form;
    logic [23:0] color_value;
    logic        frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] avg_red;
    logic [CHAN_W-1:0] avg_green;
    logic [CHAN_W-1:0] avg_blue;
    logic [COL_W-1:0]  block_col;
    logic [ROW_W-1:0]  block_row;
    logic              row_end;
  } pix_out_t;

  typedef logic [NCHAN-1:0][CHAN_W-1:0] rgb_t;
  typedef logic [NCHAN-1:0][PART_W-1:0] part_t;
  typedef logic [NCHAN-1:0][BAND_W-1:0] band_t;
  typedef logic [NCHAN-1:0][AREA_W-1:0] divisor_t;

endpackage

>>> rtl/pbad_colmem.sv
// ----------------------------------------------------------------------------
// pbad_colmem
// Band-sum store, one word of three channel sums per tile column.
// ----------------------------------------------------------------------------
module pbad_colmem import pbad_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  band_t             wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output band_t             rd_data_o
);

  band_t mem_q [MAX_WIDTH];
  band_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/pbad_div.sv
// ----------------------------------------------------------------------------
// pbad_div
// Three-lane restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pbad_div import pbad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  band_t    dividend_i,
  input  divisor_t divisor_i,
  output logic     done_o,
  output band_t    quot_o,
  output divisor_t rem_o
);

  localparam int unsigned STEPS  = 2;
  localparam int unsigned CYCLES = BAND_W / STEPS;
  localparam int unsigned CNT_W  = $clog2(CYCLES);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  band_t            quo_q, quo_d;
  divisor_t         rem_q, rem_d;
  divisor_t         dsr_q;

  always_comb begin
    logic [AREA_W:0]   t;
    logic [AREA_W-1:0] r;
    logic [BAND_W-1:0] q;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < NCHAN; k++) begin
      r = rem_q[k];
      q = quo_q[k];
      for (int s = 0; s < STEPS; s++) begin
        t = {r, q[BAND_W-1]};
        q = {q[BAND_W-2:0], 1'b0};
        if (t >= {1'b0, dsr_q[k]}) begin
          r    = AREA_W'(t - {1'b0, dsr_q[k]});
          q[0] = 1'b1;
        end else begin
          r = t[AREA_W-1:0];
        end
      end
      quo_d[k] = q;
      rem_d[k] = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(CYCLES - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/pixel_block_average_downscaler_core.sv
// ----------------------------------------------------------------------------
// pixel_block_average_downscaler_core
// Box-filter downscaler: raster pixels in, one averaged beat per full tile.
// ----------------------------------------------------------------------------
// A pixel that closes a tile's row share but not the tile passes through the
// band state: the band sum of its tile column is read from the column store
// (except on the tile's first row) and written back. A pixel that completes a
// tile instead hands the band sum to the shared divider, which works out the
// three channel means, and the block waits for it and for any stall of the
// output register. A configuration write takes the block away from pixels
// while the same divider works out the tile count per row and the tile
// coordinates of the current position. Tiles cut off at the right or bottom
// edge are dropped.
module pixel_block_average_downscaler_core import pbad_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_BAND = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_OUT  = 6'b001000,
    ST_CFG  = 6'b010000,
    ST_CFGW = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [IMG_W_W-1:0] img_w_q;
  logic [BLK_W-1:0]   blk_w_q, blk_h_q;
  logic [IMG_W_W-1:0] w_eff;
  logic [BLK_W-1:0]   bw_eff, bh_eff, bw_m1, bh_m1;
  logic [2*BLK_W-1:0] area_full;
  logic [AREA_W-1:0]  area;

  // position
  logic [COL_W-1:0]   cp_q, cp_d;
  logic [ROW_W-1:0]   rp_q, rp_d;
  logic [SUB_W-1:0]   cib_q, cib_d, rib_q, rib_d;
  logic [COL_W-1:0]   bidx_q, bidx_d;
  logic [SUB_W-1:0]   rem_q, rem_d;
  logic [ROW_W-1:0]   brow_q, brow_d;
  logic [SUB_W-1:0]   rrem_q, rrem_d;
  logic [IMG_W_W-1:0] nblk_q, nblk_d;
  part_t              part_q, part_d;

  // pending tile
  logic [COL_W-1:0]   pend_col_q, pend_col_d;
  logic [ROW_W-1:0]   pend_row_q, pend_row_d;
  logic               pend_end_q, pend_end_d;
  logic               pend_rib_nz_q, pend_rib_nz_d;
  logic               pend_last_row_q, pend_last_row_d;

  // output register
  logic               out_valid_q;
  pix_out_t           out_q;
  logic               out_free, out_load;

  logic               in_accept, cfg_accept;
  logic               tile_close;
  rgb_t               rgb;
  band_t              band_sum;
  band_t              rd_data;
  logic               rd_en, wr_en;
  logic               div_start, div_done;
  band_t              div_dividend, div_quot;
  divisor_t           div_divisor, div_rem;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;

  // size clamps
  always_comb begin
    if (img_w_q == '0) begin
      w_eff = IMG_W_W'(1);
    end else if (img_w_q > IMG_W_W'(MAX_WIDTH)) begin
      w_eff = IMG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = img_w_q;
    end
    if (blk_w_q == '0) begin
      bw_eff = BLK_W'(1);
    end else if (blk_w_q > BLK_W'(MAX_BLOCK)) begin
      bw_eff = BLK_W'(MAX_BLOCK);
    end else begin
      bw_eff = blk_w_q;
    end
    if (blk_h_q == '0) begin
      bh_eff = BLK_W'(1);
    end else if (blk_h_q > BLK_W'(MAX_BLOCK)) begin
      bh_eff = BLK_W'(MAX_BLOCK);
    end else begin
      bh_eff = blk_h_q;
    end
  end

  assign bw_m1     = bw_eff - BLK_W'(1);
  assign bh_m1     = bh_eff - BLK_W'(1);
  assign area_full = bw_eff * bh_eff;
  assign area      = area_full[AREA_W-1:0];

  // colour decode: a single hex digit widens by repeating it
  always_comb begin
    unique case (in_data_i.color_form)
      FORM_RGB6: begin
        rgb[0] = in_data_i.color_value[23:16];
        rgb[1] = in_data_i.color_value[15:8];
        rgb[2] = in_data_i.color_value[7:0];
      end
      FORM_RGB3: begin
        rgb[0] = {2{in_data_i.color_value[11:8]}};
        rgb[1] = {2{in_data_i.color_value[7:4]}};
        rgb[2] = {2{in_data_i.color_value[3:0]}};
      end
      FORM_GREY: begin
        rgb[0] = {2{in_data_i.color_value[3:0]}};
        rgb[1] = {2{in_data_i.color_value[3:0]}};
        rgb[2] = {2{in_data_i.color_value[3:0]}};
      end
      default: begin
        rgb = '0;
      end
    endcase
  end

  // pixel accept path
  always_comb begin
    logic [COL_W-1:0]   cp;
    logic [ROW_W-1:0]   rp;
    logic [SUB_W-1:0]   cib, rib, rem, rrem;
    logic [COL_W-1:0]   bidx;
    logic [ROW_W-1:0]   brow;
    logic               active, last_col, last_row;
    logic [IMG_W_W-1:0] cp_inc, rp_inc;
    logic [BLK_W-1:0]   rem_inc, rrem_inc;

    cp   = in_data_i.frame_start ? '0 : cp_q;
    rp   = in_data_i.frame_start ? '0 : rp_q;
    cib  = in_data_i.frame_start ? '0 : cib_q;
    rib  = in_data_i.frame_start ? '0 : rib_q;
    rem  = in_data_i.frame_start ? '0 : rem_q;
    rrem = in_data_i.frame_start ? '0 : rrem_q;
    bidx = in_data_i.frame_start ? '0 : bidx_q;
    brow = in_data_i.frame_start ? '0 : brow_q;

    active   = {1'b0, bidx} < nblk_q;
    last_col = {1'b0, cib} >= bw_m1;
    last_row = {1'b0, rib} >= bh_m1;

    cp_inc   = '0;
    rp_inc   = '0;
    rem_inc  = '0;
    rrem_inc = '0;

    cp_d   = cp_q;
    rp_d   = rp_q;
    cib_d  = cib_q;
    rib_d  = rib_q;
    rem_d  = rem_q;
    rrem_d = rrem_q;
    bidx_d = bidx_q;
    brow_d = brow_q;
    nblk_d = nblk_q;
    part_d = part_q;

    pend_col_d      = pend_col_q;
    pend_row_d      = pend_row_q;
    pend_end_d      = pend_end_q;
    pend_rib_nz_d   = pend_rib_nz_q;
    pend_last_row_d = pend_last_row_q;

    tile_close = in_accept && active && last_col;
    rd_en      = tile_close && (rib != '0);

    if (in_accept) begin
      if (active) begin
        for (int k = 0; k < NCHAN; k++) begin
          part_d[k] = (cib == '0) ? PART_W'(rgb[k]) : part_q[k] + PART_W'(rgb[k]);
        end
      end
      pend_col_d      = bidx;
      pend_row_d      = brow;
      pend_end_d      = ({1'b0, bidx} == nblk_q - IMG_W_W'(1));
      pend_rib_nz_d   = (rib != '0);
      pend_last_row_d = last_row;

      // advance position
      cp_inc   = {1'b0, cp} + IMG_W_W'(1);
      rem_inc  = {1'b0, rem} + BLK_W'(1);
      cib_d    = last_col ? '0 : cib + SUB_W'(1);
      if (cp_inc >= w_eff) begin
        cp_d   = '0;
        cib_d  = '0;
        rem_d  = '0;
        bidx_d = '0;
        rp_inc = {1'b0, rp} + IMG_W_W'(1);
        if (rp_inc >= IMG_W_W'(MAX_HEIGHT)) begin
          rp_d   = '0;
          rib_d  = '0;
          rrem_d = '0;
          brow_d = '0;
        end else begin
          rp_d     = rp_inc[ROW_W-1:0];
          rib_d    = last_row ? '0 : rib + SUB_W'(1);
          rrem_inc = {1'b0, rrem} + BLK_W'(1);
          if (rrem_inc == bh_eff) begin
            rrem_d = '0;
            brow_d = brow + ROW_W'(1);
          end else begin
            rrem_d = rrem_inc[SUB_W-1:0];
            brow_d = brow;
          end
        end
      end else begin
        cp_d   = cp_inc[COL_W-1:0];
        rp_d   = rp;
        rib_d  = rib;
        rrem_d = rrem;
        brow_d = brow;
        if (rem_inc == bw_eff) begin
          rem_d  = '0;
          bidx_d = bidx + COL_W'(1);
        end else begin
          rem_d  = rem_inc[SUB_W-1:0];
          bidx_d = bidx;
        end
      end
    end else if ((state_q == ST_CFGW) && div_done) begin
      // take tile count and tile coordinates from the divider
      nblk_d = div_quot[0][IMG_W_W-1:0];
      bidx_d = div_quot[1][COL_W-1:0];
      rem_d  = div_rem[1][SUB_W-1:0];
      brow_d = div_quot[2][ROW_W-1:0];
      rrem_d = div_rem[2][SUB_W-1:0];
    end
  end

  // band sum of the tile column, read-modify-write
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      band_sum[k] = BAND_W'(part_q[k]) + (pend_rib_nz_q ? rd_data[k] : '0);
    end
  end

  assign wr_en     = (state_q == ST_BAND) && !pend_last_row_q;
  assign div_start = ((state_q == ST_BAND) && pend_last_row_q) || (state_q == ST_CFG);

  always_comb begin
    if (state_q == ST_CFG) begin
      div_dividend[0] = BAND_W'(w_eff);
      div_dividend[1] = BAND_W'(cp_q);
      div_dividend[2] = BAND_W'(rp_q);
      div_divisor[0]  = AREA_W'(bw_eff);
      div_divisor[1]  = AREA_W'(bw_eff);
      div_divisor[2]  = AREA_W'(bh_eff);
    end else begin
      div_dividend = band_sum;
      for (int k = 0; k < NCHAN; k++) begin
        div_divisor[k] = area;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (((state_q == ST_DIV) && div_done) || (state_q == ST_OUT)) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cfg_accept) begin
          state_d = ST_CFG;
        end else if (tile_close) begin
          state_d = ST_BAND;
        end
      end
      ST_BAND: begin
        state_d = pend_last_row_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = out_free ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CFG: begin
        state_d = ST_CFGW;
      end
      ST_CFGW: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      img_w_q     <= IMAGE_WIDTH_RST;
      blk_w_q     <= BLOCK_WIDTH_RST;
      blk_h_q     <= BLOCK_HEIGHT_RST;
      cp_q        <= '0;
      rp_q        <= '0;
      cib_q       <= '0;
      rib_q       <= '0;
      rem_q       <= '0;
      rrem_q      <= '0;
      bidx_q      <= '0;
      brow_q      <= '0;
      nblk_q      <= IMAGE_WIDTH_RST;
      part_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cp_q    <= cp_d;
      rp_q    <= rp_d;
      cib_q   <= cib_d;
      rib_q   <= rib_d;
      rem_q   <= rem_d;
      rrem_q  <= rrem_d;
      bidx_q  <= bidx_d;
      brow_q  <= brow_d;
      nblk_q  <= nblk_d;
      part_q  <= part_d;
      if (cfg_accept) begin
        unique case (cfg_index_i)
          REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
          REG_BLOCK_WIDTH:  blk_w_q <= cfg_data_i[BLK_W-1:0];
          REG_BLOCK_HEIGHT: blk_h_q <= cfg_data_i[BLK_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_col_q      <= pend_col_d;
    pend_row_q      <= pend_row_d;
    pend_end_q      <= pend_end_d;
    pend_rib_nz_q   <= pend_rib_nz_d;
    pend_last_row_q <= pend_last_row_d;
    if (out_load) begin
      out_q.avg_red   <= div_quot[0][CHAN_W-1:0];
      out_q.avg_green <= div_quot[1][CHAN_W-1:0];
      out_q.avg_blue  <= div_quot[2][CHAN_W-1:0];
      out_q.block_col <= pend_col_q;
      out_q.block_row <= pend_row_q;
      out_q.row_end   <= pend_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pbad_colmem u_colmem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (pend_col_q),
    .wr_data_i (band_sum),
    .rd_en_i   (rd_en),
    .rd_addr_i (pend_col_d),
    .rd_data_o (rd_data)
  );

  pbad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

endmodule
